FILE: rtl/sbl_pkg.sv
// sbl_pkg: shared types and constants of the shift biquad low-pass block
// holds the command codes, register indexes, config struct and result struct
// depends on nothing
`default_nettype none

package sbl_pkg;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned ShiftWidth = 5;
  localparam int unsigned CfgDataWidth = 5;
  localparam int unsigned CfgIndexWidth = 1;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_INIT   = 1'b1;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] CFG_INPUT_SHIFT   = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CFG_DAMPING_SHIFT = 1'b1;

  localparam logic [ShiftWidth-1:0] INPUT_SHIFT_RESET   = 5'd4;
  localparam logic [ShiftWidth-1:0] DAMPING_SHIFT_RESET = 5'd2;

  typedef struct packed {
    logic [ShiftWidth-1:0] input_shift;
    logic [ShiftWidth-1:0] damping_shift;
  } cfg_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] filtered_value;
    logic                         positive_peak;
    logic                         negative_peak;
    logic signed [FieldWidth-1:0] peak_value;
    logic                         rising;
    logic                         falling;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/sbl_in_if.sv
// sbl_in_if: input request channel of the shift biquad low-pass block
// carries valid, ready, command and sample value; uses sbl_pkg
`default_nettype none

interface sbl_in_if;
  import sbl_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [FieldWidth-1:0] sample_value;

  modport source (output valid, output command, output sample_value, input ready);
  modport sink   (input valid, input command, input sample_value, output ready);

endinterface

`default_nettype wire

FILE: rtl/sbl_out_if.sv
// sbl_out_if: result request channel of the shift biquad low-pass block
// carries valid, ready and the result fields; uses sbl_pkg
`default_nettype none

interface sbl_out_if;
  import sbl_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [FieldWidth-1:0] filtered_value;
  logic                         positive_peak;
  logic                         negative_peak;
  logic signed [FieldWidth-1:0] peak_value;
  logic                         rising;
  logic                         falling;

  modport source (output valid, output filtered_value, output positive_peak,
                  output negative_peak, output peak_value, output rising,
                  output falling, input ready);
  modport sink   (input valid, input filtered_value, input positive_peak,
                  input negative_peak, input peak_value, input rising,
                  input falling, output ready);

endinterface

`default_nettype wire

FILE: rtl/sbl_cfg_regs.sv
// sbl_cfg_regs: the two shift registers behind the plain write port
// depends on sbl_pkg
`default_nettype none

module sbl_cfg_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [sbl_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  wire logic [sbl_pkg::CfgDataWidth-1:0]     cfg_wdata_i,
  output sbl_pkg::cfg_t                             cfg_o
);
  import sbl_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INPUT_SHIFT:   cfg_d.input_shift   = cfg_wdata_i[ShiftWidth-1:0];
        CFG_DAMPING_SHIFT: cfg_d.damping_shift = cfg_wdata_i[ShiftWidth-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_shift   <= INPUT_SHIFT_RESET;
      cfg_q.damping_shift <= DAMPING_SHIFT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/sbl_core.sv
// sbl_core: input and output history registers and the shift-add filter step
// produces the next result fields combinationally; depends on sbl_pkg
`default_nettype none

module sbl_core #(
  parameter int unsigned W = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                step_i,
  input  wire logic                                command_i,
  input  wire logic signed [sbl_pkg::FieldWidth-1:0] value_i,
  input  wire sbl_pkg::cfg_t                       cfg_i,
  output sbl_pkg::result_t                         res_o
);
  import sbl_pkg::*;

  localparam int unsigned AmtWidth = 8;

  logic signed [W-1:0] x0_q, x1_q, x2_q, y0_q, y1_q, y2_q;
  logic signed [W-1:0] x0_d, x1_d, x2_d, y0_d, y1_d, y2_d;
  logic signed [W-1:0] v;
  logic signed [63:0]  v_ext;
  logic signed [63:0]  y0_ext, y1_ext;
  logic [AmtWidth-1:0] amt_a, amt_am1, amt_am2, amt_b;
  logic signed [W-1:0] fb_sum, ff_sum;

  assign v_ext = 64'(value_i);
  assign v     = v_ext[W-1:0];

  // a-1 and a-2 wrap as 8-bit amounts, so small a gives pure sign fill
  assign amt_a   = AmtWidth'(cfg_i.input_shift);
  assign amt_am1 = amt_a - AmtWidth'(1);
  assign amt_am2 = amt_a - AmtWidth'(2);
  assign amt_b   = AmtWidth'(cfg_i.damping_shift);

  always_comb begin
    fb_sum = '0;
    ff_sum = '0;
    if (command_i == CMD_INIT) begin
      x0_d = v;
      x1_d = v;
      x2_d = v;
      y0_d = v;
      y1_d = v;
      y2_d = v;
    end else begin
      x0_d = v;
      x1_d = x0_q;
      x2_d = x1_q;
      y1_d = y0_q;
      y2_d = y1_q;
      fb_sum = (y1_d - y2_d) + y1_d - (y1_d >>> amt_b) + (y2_d >>> amt_b);
      ff_sum = (x0_d >>> amt_a) + (x1_d >>> amt_am1) + (x2_d >>> amt_a)
               - (y2_d >>> amt_am2);
      y0_d = fb_sum + ff_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q <= '0;
      x1_q <= '0;
      x2_q <= '0;
      y0_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (step_i) begin
      x0_q <= x0_d;
      x1_q <= x1_d;
      x2_q <= x2_d;
      y0_q <= y0_d;
      y1_q <= y1_d;
      y2_q <= y2_d;
    end
  end

  assign y0_ext = 64'(y0_d);
  assign y1_ext = 64'(y1_d);

  always_comb begin
    res_o.filtered_value = y0_ext[FieldWidth-1:0];
    res_o.peak_value     = y1_ext[FieldWidth-1:0];
    res_o.positive_peak  = (y0_d < y1_d) && !(y1_d < y2_d);
    res_o.negative_peak  = (y1_d < y0_d) && !(y2_d < y1_d);
    res_o.rising         = (y1_d < y0_d) && (y2_d < y1_d);
    res_o.falling        = (y0_d < y1_d) && (y1_d < y2_d);
  end

endmodule

`default_nettype wire

FILE: rtl/shift_biquad_lowpass_peak.sv
// shift_biquad_lowpass_peak: second-order low-pass filter with shift
// coefficients and peak and trend flags on every result.
//
// in_i carries one request per command: command 0 filters sample_value,
// command 1 loads all six history words with sample_value. Every request
// gives exactly one result on out_o: the filtered value, the previous
// output as peak value, and positive peak, negative peak, rising and
// falling flags. Both channels move a request when valid and ready are high.
// The config port writes input_shift (index 0) and damping_shift (index 1)
// when cfg_we_i is high; write it only while no request is in flight.
// A request taken on in_i is registered in the input register, goes
// through the filter step and is held in the result register that drives out_o.
// Throughput is one request per cycle while out_o is ready; the history
// feedback of the filter step is combinational, between the input register
// and the result register.
// Reset clears the histories to zero, the shifts to 4 and 2 and the
// channels to empty. When the receiver stalls, the result holds and one more
// request waits in the input register; ready drops only then.
`default_nettype none

module shift_biquad_lowpass_peak #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sbl_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [sbl_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  sbl_in_if.sink                                 in_i,
  sbl_out_if.source                              out_o
);
  import sbl_pkg::*;

  logic                         in_valid_q, in_valid_d;
  logic                         in_cmd_q;
  logic signed [FieldWidth-1:0] in_value_q;
  logic                         out_valid_q, out_valid_d;
  result_t                      res_q, res_d;
  cfg_t                         cfg;
  logic                         in_take, out_load;

  sbl_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  sbl_core #(
    .W(SAMPLE_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (out_load),
    .command_i(in_cmd_q),
    .value_i  (in_value_q),
    .cfg_i    (cfg),
    .res_o    (res_d)
  );

  // the filter step runs when the result register is free or being emptied
  assign out_load   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || out_load;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (out_load) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q   <= in_i.command;
      in_value_q <= in_i.sample_value;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.filtered_value = res_q.filtered_value;
  assign out_o.positive_peak  = res_q.positive_peak;
  assign out_o.negative_peak  = res_q.negative_peak;
  assign out_o.peak_value     = res_q.peak_value;
  assign out_o.rising         = res_q.rising;
  assign out_o.falling        = res_q.falling;

endmodule

`default_nettype wire

FILE: rtl/sbl_checker.sv
// sbl_checker: port-level assertions for shift_biquad_lowpass_peak
// bound to the top level below; depends on the top level's ports only
`default_nettype none

module sbl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] filtered_value,
  input wire logic [31:0] peak_value,
  input wire logic        positive_peak,
  input wire logic        negative_peak,
  input wire logic        rising,
  input wire logic        falling
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(filtered_value)
                                && $stable(peak_value))
    else $error("result changed while stalled");

  // input stalls only behind a full result register
  a_ready_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid)
    else $error("input stalled with result register empty");

  // peak and trend flags exclude each other
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> $onehot0({positive_peak, negative_peak, rising, falling}))
    else $error("more than one flag set");

  // a flat step raises no flag
  a_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (filtered_value == peak_value)
    |-> !positive_peak && !negative_peak && !rising && !falling)
    else $error("flag set on equal outputs");

endmodule

bind shift_biquad_lowpass_peak sbl_checker u_sbl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .filtered_value(out_o.filtered_value),
  .peak_value    (out_o.peak_value),
  .positive_peak (out_o.positive_peak),
  .negative_peak (out_o.negative_peak),
  .rising        (out_o.rising),
  .falling       (out_o.falling)
);

`default_nettype wire
